[rtl/stsg_pkg.sv]
package stsg_pkg;

  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int AMP_W       = 12;
  localparam int OFS_W       = 16;
  localparam int DAC_W       = 12;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int PH_W        = 32;
  localparam int CW          = 34;
  localparam int STAGES      = 16;
  localparam int SIN_W       = 16;
  localparam int MAX_SAMPLES = 1024;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
  localparam logic [DAC_W-1:0] DAC_MAX = '1;
  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(652032874);

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 2'd2;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] z;
  } cordic_in_t;

  typedef struct packed {
    logic                 valid;
    logic signed [CW-1:0] y;
  } cordic_out_t;

  // Angle of each micro-rotation in units of 2^-32 turn.
  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic signed [CW-1:0] a;
    case (i)
      0:  a = CW'(536870912);
      1:  a = CW'(316933406);
      2:  a = CW'(167458907);
      3:  a = CW'(85004756);
      4:  a = CW'(42667331);
      5:  a = CW'(21354465);
      6:  a = CW'(10679838);
      7:  a = CW'(5340245);
      8:  a = CW'(2670163);
      9:  a = CW'(1335087);
      10: a = CW'(667544);
      11: a = CW'(333772);
      12: a = CW'(166886);
      13: a = CW'(83443);
      14: a = CW'(41722);
      15: a = CW'(20861);
      16: a = CW'(10430);
      17: a = CW'(5215);
      18: a = CW'(2608);
      19: a = CW'(1304);
      20: a = CW'(652);
      21: a = CW'(326);
      22: a = CW'(163);
      23: a = CW'(81);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/stsg_cordic.sv]
module stsg_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  stsg_pkg::cordic_in_t  in_s,
  output stsg_pkg::cordic_out_t out_s
);
  import stsg_pkg::*;

  logic                 v_r [1:STAGES];
  logic signed [CW-1:0] x_r [1:STAGES];
  logic signed [CW-1:0] y_r [1:STAGES];
  logic signed [CW-1:0] z_r [1:STAGES];

  logic                 sv [0:STAGES-1];
  logic signed [CW-1:0] sx [0:STAGES-1];
  logic signed [CW-1:0] sy [0:STAGES-1];
  logic signed [CW-1:0] sz [0:STAGES-1];

  assign sv[0] = in_s.valid;
  assign sx[0] = CORDIC_X0;
  assign sy[0] = '0;
  assign sz[0] = in_s.z;

  for (genvar k = 1; k < STAGES; k++) begin : g_src
    assign sv[k] = v_r[k];
    assign sx[k] = x_r[k];
    assign sy[k] = y_r[k];
    assign sz[k] = z_r[k];
  end

  // One micro-rotation per stage; the shift amount is fixed by the stage.
  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic signed [CW-1:0] dx, dy;
    assign dx = sy[k] >>> k;
    assign dy = sx[k] >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!sz[k][CW-1]) begin
          x_r[k+1] <= sx[k] - dx;
          y_r[k+1] <= sy[k] + dy;
          z_r[k+1] <= sz[k] - atan_turn(k);
        end else begin
          x_r[k+1] <= sx[k] + dx;
          y_r[k+1] <= sy[k] - dy;
          z_r[k+1] <= sz[k] + atan_turn(k);
        end
      end
    end
  end

  assign out_s.valid = v_r[STAGES];
  assign out_s.y     = y_r[STAGES];

endmodule

[rtl/sine_table_sample_generator_top.sv]
// Sine table sample generator. Each input beat carries a sample index; each
// output beat carries the DAC code amplitude * sin(2*pi*(index/count + offset))
// + 2047.5, truncated and clamped to 0..4095, with a flag that is set when the
// clamp acted. The design is a single stall-together pipeline of 63 register
// stages that takes one beat every clock while the output register is free or
// being taken, and each result leaves from the last of these stages. The
// stages are one input register, ten restoring steps that reduce the index
// modulo the sample count, thirty-two restoring steps that produce the 32-bit
// phase fraction, a phase fold stage, sixteen CORDIC stages, then rounding,
// multiply and clamp stages.
// The whole pipeline holds while a result waits at the output, so in_ready
// simply mirrors the output register being free or being taken. A sample
// count of zero acts as one and counts above 1024 act as 1024. Registers are
// written through cfg_we/cfg_index/cfg_data and are to be changed only when
// no beats are in flight.
module sine_table_sample_generator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [stsg_pkg::IDX_W-1:0]         in_sample_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [stsg_pkg::DAC_W-1:0]         out_dac_code,
  output logic                               out_clipped,
  input  logic                               cfg_we,
  input  logic [stsg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [stsg_pkg::CFG_W-1:0]         cfg_data
);
  import stsg_pkg::*;

  localparam int MOD_STEPS  = IDX_W;
  localparam int FRAC_STEPS = PH_W;

  logic [CNT_W-1:0] cnt_r;
  logic [AMP_W-1:0] amp_r;
  logic [OFS_W-1:0] ofs_r;
  logic [CNT_W-1:0] cnt_eff;
  logic             en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(100);
      amp_r <= AMP_W'(2047);
      ofs_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_COUNT: cnt_r <= cfg_data[CNT_W-1:0];
        REG_AMPLITUDE:    amp_r <= cfg_data[AMP_W-1:0];
        REG_PHASE_OFFSET: ofs_r <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cnt_r == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cnt_r > MAX_CNT) begin
      cnt_eff = MAX_CNT;
    end else begin
      cnt_eff = cnt_r;
    end
  end

  // The pipeline moves as one whenever the output register can take a beat.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Index modulo count, one quotient bit per stage.
  logic             md_v_r   [0:MOD_STEPS];
  logic [IDX_W-1:0] md_idx_r [0:MOD_STEPS];
  logic [CNT_W-1:0] md_rem_r [0:MOD_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_v_r[0] <= 1'b0;
    end else if (en) begin
      md_v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_idx_r[0] <= in_sample_index;
      md_rem_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
    logic [CNT_W-1:0] t;
    assign t = {md_rem_r[k][CNT_W-2:0], md_idx_r[k][IDX_W-1-k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        md_v_r[k+1] <= 1'b0;
      end else if (en) begin
        md_v_r[k+1] <= md_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        md_idx_r[k+1] <= md_idx_r[k];
        md_rem_r[k+1] <= (t >= cnt_eff) ? t - cnt_eff : t;
      end
    end
  end

  // Fraction remainder / count, one phase bit per stage.
  logic             fr_v_r   [1:FRAC_STEPS];
  logic [CNT_W-1:0] fr_rem_r [1:FRAC_STEPS];
  logic [PH_W-1:0]  fr_q_r   [1:FRAC_STEPS];

  logic             fv   [0:FRAC_STEPS-1];
  logic [CNT_W-1:0] frem [0:FRAC_STEPS-1];
  logic [PH_W-1:0]  fq   [0:FRAC_STEPS-1];

  assign fv[0]   = md_v_r[MOD_STEPS];
  assign frem[0] = md_rem_r[MOD_STEPS];
  assign fq[0]   = '0;

  for (genvar k = 1; k < FRAC_STEPS; k++) begin : g_frsrc
    assign fv[k]   = fr_v_r[k];
    assign frem[k] = fr_rem_r[k];
    assign fq[k]   = fr_q_r[k];
  end

  for (genvar k = 0; k < FRAC_STEPS; k++) begin : g_frac
    logic [CNT_W:0] r2;
    logic [CNT_W:0] diff;
    logic           ge;
    assign r2   = {frem[k], 1'b0};
    assign ge   = r2 >= {1'b0, cnt_eff};
    assign diff = r2 - {1'b0, cnt_eff};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fr_v_r[k+1] <= 1'b0;
      end else if (en) begin
        fr_v_r[k+1] <= fv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fr_rem_r[k+1] <= ge ? diff[CNT_W-1:0] : r2[CNT_W-1:0];
        fr_q_r[k+1]   <= {fq[k][PH_W-2:0], ge};
      end
    end
  end

  // Add the offset and fold the phase into the range of plus or minus a quarter turn.
  logic [PH_W-1:0] phase, quarter, folded;
  cordic_in_t      ph_r;
  cordic_out_t     cd_s;

  assign phase   = fr_q_r[FRAC_STEPS] + {ofs_r, 16'h0000};
  assign quarter = phase + 32'h4000_0000;
  assign folded  = quarter[PH_W-1] ? 32'h8000_0000 - phase : phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r.valid <= 1'b0;
    end else if (en) begin
      ph_r.valid <= fr_v_r[FRAC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r.z <= CW'(signed'(folded));
    end
  end

  stsg_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_s  (ph_r),
    .out_s (cd_s)
  );

  // Round to Q1.15 and saturate.
  logic signed [CW-1:0]    y_rnd;
  logic signed [SIN_W-1:0] sin_nxt;
  logic signed [SIN_W-1:0] sin_r;
  logic                    sin_v_r;

  assign y_rnd = (cd_s.y + CW'(16384)) >>> 15;

  always_comb begin
    if (y_rnd > CW'(32767)) begin
      sin_nxt = 16'sh7fff;
    end else if (y_rnd < -CW'(32768)) begin
      sin_nxt = -16'sh8000;
    end else begin
      sin_nxt = y_rnd[SIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_v_r <= 1'b0;
    end else if (en) begin
      sin_v_r <= cd_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
    end
  end

  // Scale by the amplitude.
  localparam int PRD_W = AMP_W + SIN_W + 1;
  logic signed [PRD_W-1:0] prd_r;
  logic                    prd_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prd_v_r <= 1'b0;
    end else if (en) begin
      prd_v_r <= sin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prd_r <= signed'({1'b0, amp_r}) * PRD_W'(sin_r);
    end
  end

  // Add the centre code, truncate and clamp.
  localparam int T_W = PRD_W + 1;
  logic signed [T_W-1:0] t_val;
  logic signed [T_W-1:0] t_shr;
  logic [DAC_W-1:0]      code_nxt;
  logic                  clip_nxt;
  logic                  out_v_r;
  logic [DAC_W-1:0]      code_r;
  logic                  clip_r;

  assign t_val = T_W'(prd_r) + signed'(T_W'({DAC_MAX, 14'd0}));
  assign t_shr = t_val >>> 15;

  always_comb begin
    if (t_val[T_W-1]) begin
      code_nxt = '0;
      clip_nxt = 1'b1;
    end else if (t_shr > signed'(T_W'(DAC_MAX))) begin
      code_nxt = DAC_MAX;
      clip_nxt = 1'b1;
    end else begin
      code_nxt = t_shr[DAC_W-1:0];
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= prd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r <= code_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_valid    = out_v_r;
  assign out_dac_code = code_r;
  assign out_clipped  = clip_r;

endmodule
